// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence a fixed number of cycles later.
`define ASSERT_AFTER(label, clk, rst, trig, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> ##dly (cons)) \
      else $error(msg);

`endif

// ----- hdl/sdcm_pkg.sv -----
// Shared types and constants for the Duv to SDCM converter.
// No dependencies.
package sdcm_pkg;

   localparam int MAG_W   = 24;
   localparam int TEMP_W  = 17;
   localparam int STEP_W  = 15;
   localparam int DIFF_W  = 9;
   localparam int OFF_W   = 10;
   localparam int REL_W   = 13;
   localparam int PROD_W  = 19;
   localparam int Q_W     = 20;

   localparam logic [TEMP_W-1:0] TEMP_LO   = 17'd1500;
   localparam logic [TEMP_W-1:0] TEMP_HI   = 17'd100000;
   localparam logic [TEMP_W-1:0] TEMP_FLAT = 17'd8500;
   localparam int BAND_W = 1000;
   localparam int NUM_BANDS = 7;

   // floor(p / 1000) == (p * RECIP_M) >> RECIP_SHIFT for every p below 2^PROD_W
   localparam int RECIP_W     = 20;
   localparam logic [RECIP_W-1:0] RECIP_M = 20'd536871;
   localparam int RECIP_SHIFT = 29;

   localparam logic [Q_W-1:0] SDCM_MAX = 20'hFFFFF;

   // step sizes in units of 2^-24
   localparam logic [STEP_W-1:0] STEP_TABLE [8] = '{
      15'd18455, 15'd18623, 15'd18790, 15'd18958,
      15'd19294, 15'd19629, 15'd19797, 15'd20133
   };

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [MAG_W-1:0]  mag;
      logic [STEP_W-1:0] step;
   } front_type;

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic              sat;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] rem;
      logic [Q_W-1:0]    bits;
   } cell_type;

endpackage

// ----- hdl/sdcm_step_calc.sv -----
// Front pipeline: magnitude of Duv, range check and interpolated step size.
// Depends on sdcm_pkg.
module sdcm_step_calc import sdcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic signed [MAG_W-1:0]  duv,
   input  logic [TEMP_W-1:0]        color_temp,
   output front_type                front
);

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              oor1_ff, oor2_ff, oor3_ff, oor4_ff;
   logic              flat1_ff, flat2_ff, flat3_ff;
   logic [MAG_W-1:0]  mag1_ff, mag2_ff, mag3_ff, mag4_ff;
   logic [OFF_W-1:0]  off1_ff;
   logic [STEP_W-1:0] lo1_ff, lo2_ff, lo3_ff, step4_ff;
   logic [DIFF_W-1:0] diff1_ff;
   logic [PROD_W-1:0] prod2_ff;
   logic [DIFF_W-1:0] interp3_ff;

   logic              oor1_in, flat1_in;
   logic [MAG_W-1:0]  mag1_in;
   logic [TEMP_W-1:0] rel_full;
   logic [REL_W-1:0]  rel;
   logic [2:0]        band;
   logic [REL_W-1:0]  base;
   logic [OFF_W-1:0]  off1_in;
   logic [STEP_W-1:0] lo1_in, hi1;
   logic [DIFF_W-1:0] diff1_in;
   logic [PROD_W+RECIP_W-1:0] recip_prod;

   always_comb begin
      oor1_in  = (color_temp < TEMP_LO) || (color_temp > TEMP_HI);
      flat1_in = (color_temp >= TEMP_FLAT);
      mag1_in  = duv[MAG_W-1] ? MAG_W'(-duv) : MAG_W'(duv);
      rel_full = color_temp - TEMP_LO;
      rel      = rel_full[REL_W-1:0];
      band     = 3'd0;
      base     = '0;
      for (int k = 1; k < NUM_BANDS; k++) begin
         if (rel >= REL_W'(k * BAND_W)) begin
            band = 3'(k);
            base = REL_W'(k * BAND_W);
         end
      end
      off1_in  = OFF_W'(rel - base);
      lo1_in   = STEP_TABLE[band];
      hi1      = STEP_TABLE[3'(band + 3'd1)];
      diff1_in = DIFF_W'(hi1 - lo1_in);
   end

   assign recip_prod = (PROD_W+RECIP_W)'(prod2_ff) * (PROD_W+RECIP_W)'(RECIP_M);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      // split band and offset
      oor1_ff  <= oor1_in;
      flat1_ff <= flat1_in;
      mag1_ff  <= mag1_in;
      off1_ff  <= off1_in;
      lo1_ff   <= lo1_in;
      diff1_ff <= diff1_in;
      // offset times slope
      oor2_ff  <= oor1_ff;
      flat2_ff <= flat1_ff;
      mag2_ff  <= mag1_ff;
      lo2_ff   <= lo1_ff;
      prod2_ff <= PROD_W'(off1_ff * diff1_ff);
      // divide by the band width
      oor3_ff    <= oor2_ff;
      flat3_ff   <= flat2_ff;
      mag3_ff    <= mag2_ff;
      lo3_ff     <= lo2_ff;
      interp3_ff <= DIFF_W'(recip_prod >> RECIP_SHIFT);
      // add the base step, hold the last step from the flat point on
      oor4_ff  <= oor3_ff;
      mag4_ff  <= mag3_ff;
      step4_ff <= flat3_ff ? STEP_TABLE[7] : STEP_W'(lo3_ff + STEP_W'(interp3_ff));
   end

   assign front.valid = v4_ff;
   assign front.oor   = oor4_ff;
   assign front.mag   = mag4_ff;
   assign front.step  = step4_ff;

endmodule

// ----- hdl/sdcm_div_cell.sv -----
// One restoring-division cell: develops one quotient bit per cycle.
// Depends on sdcm_pkg.
module sdcm_div_cell import sdcm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type cell_i,
   output cell_type cell_o
);

   cell_type         cell_ff;
   cell_type         cell_in;
   logic [STEP_W:0]  trial;
   logic             ge;

   always_comb begin
      trial   = {cell_i.rem, cell_i.bits[Q_W-1]};
      ge      = (trial >= {1'b0, cell_i.step});
      cell_in = cell_i;
      cell_in.rem  = ge ? STEP_W'(trial - {1'b0, cell_i.step}) : trial[STEP_W-1:0];
      cell_in.bits = {cell_i.bits[Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

// ----- hdl/duv_to_sdcm_converter.sv -----
// Top level of the Duv to SDCM converter: front pipeline and divider cell chain.
// Depends on sdcm_pkg, sdcm_step_calc and sdcm_div_cell.
//
// Usage:
//   Input channel: drive req_duv and req_color_temp with start high. An item is
//   taken at each rising edge with start high and busy low. busy is high only
//   while reset is asserted, so one item can enter on every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle per item, with
//   rsp_sdcm and rsp_out_of_range valid in that cycle. Results leave in the
//   order items entered. The receiver cannot stall; it must take each result
//   in the cycle it is shown.
//   Pipeline: 4 step-size stages, 1 divider setup stage, 20 divider cells and
//   the output register. Throughput: one item per cycle. Step size: band
//   lookup, offset times slope, multiply by a reciprocal of the band width,
//   then add the band base, or hold the last step from the flat point on.
//   Division: a chain of 20 identical cells, one quotient bit each; the setup
//   stage flags saturation up front.
//   Reset: synchronous; clears all valid flags so no stale result appears.
//   SDCM_FRAC_BITS sets the fraction bits of rsp_sdcm (0..16).
module duv_to_sdcm_converter import sdcm_pkg::*; #(
   parameter int SDCM_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [MAG_W-1:0]  req_duv,
   input  logic [TEMP_W-1:0]        req_color_temp,
   output logic                     rsp_strobe,
   output logic [Q_W-1:0]           rsp_sdcm,
   output logic                     rsp_out_of_range
);

   // dividend width, and the width used for its part above the quotient bits (at least STEP_W)
   localparam int DW = MAG_W + SDCM_FRAC_BITS;
   localparam int CW = (DW - Q_W > STEP_W) ? (DW - Q_W) : STEP_W;

   logic       accept;
   front_type  front;
   cell_type   head_ff, head_in;
   cell_type   chain [Q_W+1];
   logic [DW-1:0] dividend;
   logic [CW-1:0] upper;

   logic           strobe_ff;
   logic [Q_W-1:0] sdcm_ff, sdcm_in;
   logic           oor_ff;

   // hold off new items only during reset
   assign busy   = reset;
   assign accept = start && !busy;

   sdcm_step_calc u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .duv        (req_duv),
      .color_temp (req_color_temp),
      .front      (front)
   );

   // Setup stage: scale the magnitude, then check whether the quotient
   // fits in Q_W bits. If the part above the quotient bits is already at
   // least the step, the quotient overflows and the result saturates.
   always_comb begin
      dividend = DW'(front.mag) << SDCM_FRAC_BITS;
      upper    = CW'(dividend >> Q_W);
      head_in.valid = front.valid;
      head_in.oor   = front.oor;
      head_in.step  = front.step;
      head_in.sat   = (upper >= CW'(front.step));
      head_in.rem   = head_in.sat ? '0 : upper[STEP_W-1:0];
      head_in.bits  = dividend[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   // one cell per quotient bit, most significant first
   for (genvar g = 0; g < Q_W; g++) begin : g_cell
      sdcm_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cell_i (chain[g]),
         .cell_o (chain[g+1])
      );
   end

   // Output register: force zero out of range, saturate on overflow.
   always_comb begin
      if (chain[Q_W].oor) begin
         sdcm_in = '0;
      end else if (chain[Q_W].sat) begin
         sdcm_in = SDCM_MAX;
      end else begin
         sdcm_in = chain[Q_W].bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain[Q_W].valid;
      end
      sdcm_ff <= sdcm_in;
      oor_ff  <= chain[Q_W].oor;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_sdcm         = sdcm_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

// ----- hdl/sdcm_checker.sv -----
// Port-level checker for the Duv to SDCM converter, bound to the top level.
// Depends on sdcm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdcm_checker import sdcm_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [TEMP_W-1:0]        req_color_temp,
   input logic                     rsp_strobe,
   input logic [Q_W-1:0]           rsp_sdcm,
   input logic                     rsp_out_of_range
);

   localparam int LATENCY = 26;

   logic acc, temp_bad;

   assign acc      = start && !busy;
   assign temp_bad = (req_color_temp < TEMP_LO) || (req_color_temp > TEMP_HI);

   `ASSERT_ALWAYS(a_oor_zero, clock, reset, rsp_strobe && rsp_out_of_range |-> rsp_sdcm == '0, "out-of-range result with nonzero sdcm")
   `ASSERT_AFTER(a_no_spurious, clock, reset, !acc, LATENCY, !rsp_strobe, "result without an accepted item")
   `ASSERT_AFTER(a_oor_flag, clock, reset, acc && temp_bad, LATENCY, rsp_strobe && rsp_out_of_range, "out-of-range item not flagged")
   `ASSERT_AFTER(a_in_range, clock, reset, acc && !temp_bad, LATENCY, rsp_strobe && !rsp_out_of_range, "in-range item lost or flagged")

endmodule

bind duv_to_sdcm_converter sdcm_checker u_sdcm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_color_temp   (req_color_temp),
   .rsp_strobe       (rsp_strobe),
   .rsp_sdcm         (rsp_sdcm),
   .rsp_out_of_range (rsp_out_of_range)
);

// ----- test/tb_duv_to_sdcm_converter.sv -----
// Self-checking testbench for duv_to_sdcm_converter: directed and random Duv/temperature
// items, an in-bench step-size and divide predictor, and an in-order result scoreboard.
// Depends on sdcm_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_duv_to_sdcm_converter;
   import sdcm_pkg::*;

   localparam int FRAC_BITS = 8;
   localparam int RANDOM_READINGS = 1100;
   localparam int DRAIN_CYCLES = 40;        // leave slack beyond the converter pipeline
   localparam int CYCLE_LIMIT = 200000;

   // Temperature limits in kelvin and the saturation value of the step count.
   localparam int unsigned K_MIN  = 1500;
   localparam int unsigned K_FLAT = 8500;
   localparam int unsigned K_MAX  = 100000;
   localparam int unsigned BAND_K = 1000;
   localparam longint unsigned SDCM_SAT = 64'd1048575;

   // MacAdam step sizes in units of 2^-24, one per 1000 K band starting at 1500 K.
   localparam int unsigned step_lut [8] = '{
      18455, 18623, 18790, 18958, 19294, 19629, 19797, 20133
   };

   // One measurement offered to the converter, with the pacing that goes with it.
   typedef struct {
      logic signed [MAG_W-1:0] duv;
      logic [TEMP_W-1:0]       temp;
      int                      idle_pct;   // chance of a sender gap before this item
      bit                      drain;      // hold this item until all results are back
   } reading_type;

   // Predicted result, kept with the measurement that caused it for reporting.
   typedef struct {
      logic signed [MAG_W-1:0] duv;
      logic [TEMP_W-1:0]       temp;
      logic [Q_W-1:0]          sdcm;
      logic                    oor;
   } sdcm_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic signed [MAG_W-1:0] req_duv = '0;
   logic [TEMP_W-1:0]       req_color_temp = '0;
   logic                    rsp_strobe;
   logic [Q_W-1:0]          rsp_sdcm;
   logic                    rsp_out_of_range;

   reading_type     pending_readings [$];
   sdcm_result_type expected_sdcm [$];
   bit              took_item = 1'b0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   duv_to_sdcm_converter #(
      .SDCM_FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_duv(req_duv),
      .req_color_temp(req_color_temp),
      .rsp_strobe(rsp_strobe),
      .rsp_sdcm(rsp_sdcm),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always #5 clock = ~clock;

   // Step size for an in-range temperature, then |duv| scaled by 2^FRAC_BITS over
   // that step, truncated and saturated. Outside 1500..100000 K flag and return zero.
   function automatic sdcm_result_type predict_sdcm(logic signed [MAG_W-1:0] duv,
                                                    logic [TEMP_W-1:0] temp);
      sdcm_result_type r;
      logic [MAG_W-1:0] mag;
      int unsigned     rel;
      int unsigned     band;
      int unsigned     off;
      int unsigned     step;
      longint unsigned scaled;
      longint unsigned quot;
      r.duv  = duv;
      r.temp = temp;
      r.sdcm = '0;
      r.oor  = 1'b0;
      if (temp < K_MIN || temp > K_MAX) begin
         r.oor = 1'b1;
         return r;
      end
      // unsigned 24-bit negate: the most negative Duv comes out as 2^23 exactly
      mag = duv[MAG_W-1] ? -duv : duv;
      if (temp >= K_FLAT) begin
         step = step_lut[7];
      end else begin
         rel  = temp - K_MIN;
         band = rel / BAND_K;
         off  = rel % BAND_K;
         // truncate the interpolation term toward this band's step
         step = step_lut[band] + (off * (step_lut[band + 1] - step_lut[band])) / BAND_K;
      end
      scaled = 64'(mag);
      scaled = scaled << FRAC_BITS;
      quot   = scaled / step;
      r.sdcm = (quot > SDCM_SAT) ? SDCM_SAT[Q_W-1:0] : quot[Q_W-1:0];
      return r;
   endfunction

   task automatic add_reading(logic signed [MAG_W-1:0] duv, logic [TEMP_W-1:0] temp,
                              int idle_pct, bit drain);
      reading_type rd;
      rd.duv      = duv;
      rd.temp     = temp;
      rd.idle_pct = idle_pct;
      rd.drain    = drain;
      pending_readings.push_back(rd);
   endtask

   // Driver: change inputs on the falling edge. Present the next item once the
   // current one has been taken (or nothing is offered), unless a random gap or a
   // drain pause holds it back.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || took_item) begin
         if (pending_readings.size() == 0 ||
             (pending_readings[0].drain && expected_sdcm.size() != 0) ||
             ($urandom_range(99) < pending_readings[0].idle_pct)) begin
            start <= 1'b0;
         end else begin
            start          <= 1'b1;
            req_duv        <= pending_readings[0].duv;
            req_color_temp <= pending_readings[0].temp;
            void'(pending_readings.pop_front());
         end
      end
   end

   // Monitor: sample on the rising edge. Compare each strobed result with the
   // oldest prediction, then record a prediction for any item taken at this edge.
   always @(posedge clock) begin : monitor
      sdcm_result_type want;
      bit              have;
      if (reset) begin
         took_item <= 1'b0;
      end else begin
         took_item <= start && !busy;
         if (rsp_strobe) begin
            have = expected_sdcm.size() != 0;
            want = '{duv: '0, temp: '0, sdcm: '0, oor: 1'b0};
            if (have)
               want = expected_sdcm.pop_front();
            if (!have || want.sdcm !== rsp_sdcm || want.oor !== rsp_out_of_range) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("sdcm %0s: duv=%0d temp=%0d expected sdcm=%0d oor=%0b, got sdcm=%0d oor=%0b",
                           have ? "mismatch" : "result with nothing pending",
                           want.duv, want.temp, want.sdcm, want.oor,
                           rsp_sdcm, rsp_out_of_range);
            end
         end
         if (start && !busy)
            expected_sdcm.push_back(predict_sdcm(req_duv, req_color_temp));
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                      phase;
      int                      pct;
      logic signed [MAG_W-1:0] duv;
      logic [TEMP_W-1:0]       temp;

      // Directed: full-scale and zero Duv, both range limits and their neighbors,
      // band boundaries, the start of the flat region, and the 17-bit maximum.
      add_reading(24'sd0,        17'd1500,   0, 1'b0);
      add_reading(24'sd8388607,  17'd1500,   0, 1'b0);
      add_reading(-24'sd8388608, 17'd1500,   0, 1'b0);
      add_reading(-24'sd1,       17'd1501,   0, 1'b0);
      add_reading(24'sd1,        17'd2500,   0, 1'b0);
      add_reading(24'sd8388607,  17'd2499,   0, 1'b0);
      add_reading(-24'sd8388608, 17'd8499,   0, 1'b0);
      add_reading(24'sd8388607,  17'd8500,   0, 1'b0);
      add_reading(-24'sd8388607, 17'd100000, 0, 1'b0);
      add_reading(24'sd8388607,  17'd100001, 0, 1'b0);
      add_reading(24'sd8388607,  17'd1499,   0, 1'b0);
      add_reading(-24'sd8388608, 17'd0,      0, 1'b0);
      add_reading(24'sd123456,   17'd131071, 0, 1'b0);
      add_reading(-24'sd123456,  17'd3500,   0, 1'b0);
      add_reading(24'sd500000,   17'd4500,   0, 1'b0);
      add_reading(-24'sd500000,  17'd5500,   0, 1'b0);
      add_reading(24'sd777777,   17'd6500,   0, 1'b0);
      add_reading(-24'sd777777,  17'd7500,   0, 1'b0);
      add_reading(24'sd4000000,  17'd5000,   0, 1'b0);
      add_reading(-24'sd4000000, 17'd65536,  0, 1'b0);
      add_reading(24'sd1000,     17'd99999,  0, 1'b0);
      add_reading(-24'sd1000,    17'd8000,   0, 1'b0);

      // Random: three pacing phases (light gaps, heavy gaps, back to back), with a
      // full drain every 250 items so the pipeline also restarts from empty.
      for (int i = 0; i < RANDOM_READINGS; i++) begin
         phase = (i * 3) / RANDOM_READINGS;
         pct   = (phase == 0) ? 27 : (phase == 1) ? 54 : 0;
         case ($urandom_range(9))
            0: duv = $urandom_range(1) ? -24'sd8388608 : 24'sd8388607;
            1, 2: begin
               duv = MAG_W'($urandom_range(2047));
               if ($urandom_range(1))
                  duv = -duv;
            end
            default: duv = MAG_W'($urandom());
         endcase
         case ($urandom_range(19))
            0: temp = TEMP_W'($urandom_range(K_MIN - 1));
            1: temp = TEMP_W'($urandom_range(131071, K_MAX + 1));
            2: temp = TEMP_W'(K_MIN + BAND_K * $urandom_range(7));
            3: begin
               case ($urandom_range(3))
                  0: temp = TEMP_W'(K_MIN - 1);
                  1: temp = TEMP_W'(K_MIN);
                  2: temp = TEMP_W'(K_MAX);
                  default: temp = TEMP_W'(K_MAX + 1);
               endcase
            end
            4, 5, 6: temp = TEMP_W'($urandom_range(K_MAX, K_FLAT));
            default: temp = TEMP_W'($urandom_range(K_FLAT - 1, K_MIN));
         endcase
         add_reading(duv, temp, pct, (i % 250) == 0);
      end

      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Wait for every item to be taken and every result to come back, then let
      // the pipeline run dry to catch any stray strobe.
      while (pending_readings.size() != 0 || start || expected_sdcm.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sdcm_pkg.sv
hdl/sdcm_step_calc.sv
hdl/sdcm_div_cell.sv
hdl/duv_to_sdcm_converter.sv
hdl/sdcm_checker.sv
test/tb_duv_to_sdcm_converter.sv
